>>> hw/rtl/dsrc_pkg.sv
// ----------------------------------------------------------------------------
// Download stall/retry controller package
// Shared widths, codes and reset values for the stall watchdog.
// ----------------------------------------------------------------------------
package dsrc_pkg;

  localparam int unsigned BYTE_COUNT_WIDTH = 48;
  localparam int unsigned COUNTER_WIDTH    = 16;

  localparam int unsigned FuncW    = 2;
  localparam int unsigned ActionW  = 2;
  localparam int unsigned WaitRegW = 16;
  localparam int unsigned RstRegW  = 8;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [WaitRegW-1:0] MaxWaitTicksRst     = 16'd600;
  localparam logic [RstRegW-1:0]  MaxErrorRestartsRst = 8'd3;
  localparam logic [WaitRegW-1:0] StallLimitRst       = 16'd20;

  typedef enum logic [FuncW-1:0] {
    FUNC_TICK       = 2'd0,
    FUNC_BEGIN_WAIT = 2'd1,
    FUNC_RESET      = 2'd2
  } func_e;

  typedef enum logic [ActionW-1:0] {
    ACT_WAIT    = 2'd0,
    ACT_REPLAY  = 2'd1,
    ACT_GIVE_UP = 2'd2
  } action_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MAX_WAIT_TICKS     = 2'd0,
    CFG_MAX_ERROR_RESTARTS = 2'd1,
    CFG_STALL_LIMIT        = 2'd2
  } cfg_idx_e;

endpackage

>>> hw/rtl/dsrc_intf.sv
// ----------------------------------------------------------------------------
// Download stall/retry controller channels
// Valid/ready request and response channels of the watchdog.
// ----------------------------------------------------------------------------
interface dsrc_req_if #(
  parameter int unsigned BYTE_COUNT_WIDTH = dsrc_pkg::BYTE_COUNT_WIDTH
) ();
  logic                              valid;
  logic                              ready;
  logic [dsrc_pkg::FuncW-1:0]        func;
  logic                              progress_known;
  logic [BYTE_COUNT_WIDTH-1:0]       downloaded_bytes;
  logic [BYTE_COUNT_WIDTH-1:0]       total_bytes;
  logic                              entry_errored;

  modport source (
    output valid, func, progress_known, downloaded_bytes, total_bytes, entry_errored,
    input  ready
  );
  modport sink (
    input  valid, func, progress_known, downloaded_bytes, total_bytes, entry_errored,
    output ready
  );
endinterface

interface dsrc_rsp_if ();
  logic                         valid;
  logic                         ready;
  logic [dsrc_pkg::ActionW-1:0] action;

  modport source (output valid, action, input ready);
  modport sink   (input valid, action, output ready);
endinterface

>>> hw/rtl/download_stall_retry_controller_core.sv
// ----------------------------------------------------------------------------
// Download stall/retry controller
// Tick watchdog answering wait, replay or give-up for a running download.
// ----------------------------------------------------------------------------
// Response path: an accepted request enters the input register; a tick's action
//   is then held in the response register until taken.
// Throughput: one request per cycle (single state update) while rsp_o is free.
// Reset: asynchronous, active low; counters clear, limits return to 600/3/20.
// ----------------------------------------------------------------------------
module download_stall_retry_controller_core #(
  parameter int unsigned BYTE_COUNT_WIDTH = dsrc_pkg::BYTE_COUNT_WIDTH,
  parameter int unsigned COUNTER_WIDTH    = dsrc_pkg::COUNTER_WIDTH
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [dsrc_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [dsrc_pkg::CfgDataW-1:0]   cfg_data_i,
  dsrc_req_if.sink                        req_i,
  dsrc_rsp_if.source                      rsp_o
);

  localparam int unsigned CmpW =
    (COUNTER_WIDTH > dsrc_pkg::WaitRegW) ? COUNTER_WIDTH : dsrc_pkg::WaitRegW;

  // configuration
  logic [dsrc_pkg::WaitRegW-1:0] max_wait_q, stall_lim_q;
  logic [dsrc_pkg::RstRegW-1:0]  max_rst_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_wait_q  <= dsrc_pkg::MaxWaitTicksRst;
      max_rst_q   <= dsrc_pkg::MaxErrorRestartsRst;
      stall_lim_q <= dsrc_pkg::StallLimitRst;
    end else if (cfg_we_i) begin
      case (dsrc_pkg::cfg_idx_e'(cfg_idx_i))
        dsrc_pkg::CFG_MAX_WAIT_TICKS:     max_wait_q  <= cfg_data_i;
        dsrc_pkg::CFG_MAX_ERROR_RESTARTS: max_rst_q   <= cfg_data_i[dsrc_pkg::RstRegW-1:0];
        dsrc_pkg::CFG_STALL_LIMIT:        stall_lim_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input register
  logic                          in_vld_q;
  logic [dsrc_pkg::FuncW-1:0]    func_q;
  logic                          known_q, err_q;
  logic [BYTE_COUNT_WIDTH-1:0]   done_q, total_q;

  // watchdog state
  logic [COUNTER_WIDTH-1:0]      wait_q, wait_d, stall_q, stall_d;
  logic [BYTE_COUNT_WIDTH-1:0]   last_q, last_d;
  logic [dsrc_pkg::RstRegW-1:0]  rst_used_q, rst_used_d;

  // response register
  logic                          out_vld_q;
  logic [dsrc_pkg::ActionW-1:0]  action_q;

  logic                          is_tick, out_free, adv;
  logic [COUNTER_WIDTH-1:0]      wait_inc, stall_inc;
  dsrc_pkg::action_e             act;

  assign is_tick  = (dsrc_pkg::func_e'(func_q) == dsrc_pkg::FUNC_TICK);
  assign out_free = !out_vld_q || rsp_o.ready;
  assign adv      = in_vld_q && (out_free || !is_tick);

  assign req_i.ready  = !in_vld_q || adv;
  assign rsp_o.valid  = out_vld_q;
  assign rsp_o.action = action_q;

  assign wait_inc  = (&wait_q)  ? wait_q  : wait_q + 1'b1;
  assign stall_inc = (&stall_q) ? stall_q : stall_q + 1'b1;

  always_comb begin
    wait_d     = wait_q;
    stall_d    = stall_q;
    last_d     = last_q;
    rst_used_d = rst_used_q;
    act        = dsrc_pkg::ACT_WAIT;
    case (dsrc_pkg::func_e'(func_q))
      dsrc_pkg::FUNC_TICK: begin
        wait_d = wait_inc;
        if (CmpW'(wait_inc) > CmpW'(max_wait_q)) begin
          act = dsrc_pkg::ACT_GIVE_UP;
        end else if (err_q) begin
          if (rst_used_q < max_rst_q) begin
            rst_used_d = (&rst_used_q) ? rst_used_q : rst_used_q + 1'b1;
            act        = dsrc_pkg::ACT_REPLAY;
          end else begin
            act = dsrc_pkg::ACT_GIVE_UP;
          end
        end else if (known_q && (total_q != '0) && (done_q >= total_q)) begin
          act = dsrc_pkg::ACT_REPLAY;
        end else if (known_q && (done_q > last_q)) begin
          last_d  = done_q;
          stall_d = '0;
        end else begin
          stall_d = stall_inc;
          if (CmpW'(stall_inc) >= CmpW'(stall_lim_q)) begin
            act = dsrc_pkg::ACT_REPLAY;
          end
        end
      end
      dsrc_pkg::FUNC_BEGIN_WAIT: begin
        wait_d  = '0;
        stall_d = '0;
        last_d  = '0;
      end
      dsrc_pkg::FUNC_RESET: begin
        wait_d     = '0;
        stall_d    = '0;
        last_d     = '0;
        rst_used_d = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q   <= 1'b0;
      out_vld_q  <= 1'b0;
      wait_q     <= '0;
      stall_q    <= '0;
      last_q     <= '0;
      rst_used_q <= '0;
    end else begin
      if (req_i.ready) begin
        in_vld_q <= req_i.valid;
      end
      if (adv) begin
        wait_q     <= wait_d;
        stall_q    <= stall_d;
        last_q     <= last_d;
        rst_used_q <= rst_used_d;
      end
      if (out_free) begin
        out_vld_q <= adv && is_tick;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      func_q  <= req_i.func;
      known_q <= req_i.progress_known;
      done_q  <= req_i.downloaded_bytes;
      total_q <= req_i.total_bytes;
      err_q   <= req_i.entry_errored;
    end
    if (adv && is_tick) begin
      action_q <= act;
    end
  end

endmodule

>>> hw/rtl/dsrc_checker.sv
// ----------------------------------------------------------------------------
// Download stall/retry controller checker
// Port-level assertions on the watchdog, bound to the top level.
// ----------------------------------------------------------------------------
module dsrc_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         req_valid_i,
  input logic                         req_ready_i,
  input logic                         rsp_valid_i,
  input logic                         rsp_ready_i,
  input logic [dsrc_pkg::ActionW-1:0] rsp_action_i
);

  // legal action codes only
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (rsp_action_i == dsrc_pkg::ACT_WAIT ||
                     rsp_action_i == dsrc_pkg::ACT_REPLAY ||
                     rsp_action_i == dsrc_pkg::ACT_GIVE_UP))
    else $error("dsrc: illegal action code");

  // a fresh response must come from a request accepted ahead of the input and response registers
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_i) |-> $past(req_valid_i && req_ready_i, 2))
    else $error("dsrc: response without request");

  // back-pressure only from a stalled response
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_ready_i |-> (rsp_valid_i && !rsp_ready_i))
    else $error("dsrc: request stalled with response side free");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && !rsp_ready_i) |=> rsp_valid_i)
    else $error("dsrc: response dropped");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && !rsp_ready_i) |=> $stable(rsp_action_i))
    else $error("dsrc: response changed while stalled");

endmodule

bind download_stall_retry_controller_core dsrc_checker u_dsrc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .rsp_action_i (rsp_o.action)
);
